[hdl/csl_pkg.sv]
// Shared types, codes and per-byte parse function for the crontab line checker.
// Used by csl_parser, csl_out_stage and cron_schedule_line_checker_core.
`timescale 1ns / 1ps

package csl_pkg;

  // Parse phases of one line
  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SKIP = 3'd1,
    PH_STAR = 3'd2,
    PH_NUM1 = 3'd3,
    PH_DASH = 3'd4,
    PH_NUM2 = 3'd5,
    PH_LIST = 3'd6,
    PH_TAIL = 3'd7
  } csl_phase_e;

  // Line verdict codes
  typedef enum logic [2:0] {
    V_VALID    = 3'd0,
    V_COMMENT  = 3'd1,
    V_EOLN     = 3'd2,
    V_UNEXPECT = 3'd3,
    V_BOUND    = 3'd4
  } csl_verdict_e;

  localparam logic [2:0] FieldLast  = 3'd4;
  localparam logic [2:0] FieldTrail = 3'd5;
  localparam logic [6:0] NumSat     = 7'd127;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_in_line;
    logic       new_file;
  } csl_in_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic [2:0] error_field;
    logic       file_has_error;
  } csl_out_t;

  // Per-line parser state
  typedef struct packed {
    logic [2:0]   field_pos;
    csl_phase_e   phase;
    logic [6:0]   num;
    csl_verdict_e verdict;
    logic         decided;
  } csl_state_t;

  function automatic logic [6:0] csl_low_bound(logic [2:0] f);
    logic [6:0] r;
    case (f)
      3'd2, 3'd3: r = 7'd1;
      default:    r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] csl_high_bound(logic [2:0] f);
    logic [6:0] r;
    case (f)
      3'd0:    r = 7'd59;
      3'd1:    r = 7'd23;
      3'd2:    r = 7'd31;
      3'd3:    r = 7'd12;
      3'd4:    r = 7'd6;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Advance the parser by one byte; a NUL byte stands for end of string
  function automatic csl_state_t csl_take(csl_state_t s, logic [7:0] c);
    csl_state_t  r;
    logic        blank;
    logic        digit;
    logic [10:0] prod;
    logic        bad;
    r     = s;
    blank = (c == ChSpace) || (c == ChTab);
    digit = (c >= ChZero) && (c <= ChNine);
    prod  = {4'd0, s.num} * 11'd10 + {7'd0, c[3:0]};
    bad   = (s.num < csl_low_bound(s.field_pos)) || (s.num > csl_high_bound(s.field_pos));
    case (s.phase)
      PH_LEAD, PH_SKIP, PH_LIST: begin
        if (s.phase != PH_LIST && blank) begin
          r = s;
        end else if (s.phase == PH_LEAD && (c == ChHash || c == ChLf)) begin
          r.verdict = V_COMMENT;
          r.decided = 1'b1;
        end else if (s.phase != PH_LIST && c == ChNul) begin
          r.verdict = V_EOLN;
          r.decided = 1'b1;
        end else if (s.phase != PH_LIST && c == ChStar) begin
          r.phase = PH_STAR;
        end else if (digit) begin
          r.num   = {3'd0, c[3:0]};
          r.phase = PH_NUM1;
        end else begin
          r.verdict = V_UNEXPECT;
          r.decided = 1'b1;
        end
      end
      PH_STAR: begin
        if (blank) begin
          if (s.field_pos >= FieldLast) begin
            r.field_pos = FieldTrail;
            r.phase     = PH_TAIL;
          end else begin
            r.field_pos = s.field_pos + 3'd1;
            r.phase     = PH_SKIP;
          end
        end else begin
          r.verdict = V_UNEXPECT;
          r.decided = 1'b1;
        end
      end
      PH_NUM1, PH_NUM2: begin
        if (digit) begin
          r.num = (prod > {4'd0, NumSat}) ? NumSat : prod[6:0];
        end else if (bad) begin
          r.verdict = V_BOUND;
          r.decided = 1'b1;
        end else if (s.phase == PH_NUM1 && c == ChDash) begin
          r.phase = PH_DASH;
        end else if (blank) begin
          if (s.field_pos >= FieldLast) begin
            r.field_pos = FieldTrail;
            r.phase     = PH_TAIL;
          end else begin
            r.field_pos = s.field_pos + 3'd1;
            r.phase     = PH_SKIP;
          end
        end else if (c == ChNul) begin
          r.verdict = V_EOLN;
          r.decided = 1'b1;
        end else if (c == ChComma) begin
          r.phase = PH_LIST;
        end else begin
          r.verdict = V_UNEXPECT;
          r.decided = 1'b1;
        end
      end
      PH_DASH: begin
        if (digit) begin
          r.num   = {3'd0, c[3:0]};
          r.phase = PH_NUM2;
        end else begin
          r.verdict = V_UNEXPECT;
          r.decided = 1'b1;
        end
      end
      default: begin
        r.verdict = (c == ChNul) ? V_EOLN : V_VALID;
        r.decided = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/csl_parser.sv]
// Line parser: holds per-line state and the sticky file error, consumes one byte per beat.
// Depends on csl_pkg for state types and the per-byte parse function.
`timescale 1ns / 1ps

module csl_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  csl_pkg::csl_in_t  data_i,
  output logic              res_valid_o,
  output csl_pkg::csl_out_t res_o
);
  import csl_pkg::*;

  localparam csl_state_t StateClear = '{
    field_pos: 3'd0, phase: PH_LEAD, num: 7'd0, verdict: V_VALID, decided: 1'b0
  };

  csl_state_t state_q, state_d;
  csl_state_t st_a, st_b;
  logic       sticky_q, sticky_d;
  logic       sticky_base;
  logic       err_now;

  // Run the byte, then the end-of-string mark on the final byte
  always_comb begin
    st_a        = state_q.decided ? state_q : csl_take(state_q, data_i.ch);
    st_b        = (!st_a.decided && data_i.last_in_line) ? csl_take(st_a, ChNul) : st_a;
    sticky_base = data_i.new_file ? 1'b0 : sticky_q;
    err_now     = st_b.decided && !state_q.decided && (st_b.verdict >= V_EOLN);
    sticky_d    = sticky_base | err_now;
    state_d     = data_i.last_in_line ? StateClear : st_b;
  end

  // Build the result beat for the final byte
  always_comb begin
    res_valid_o          = fire_i && data_i.last_in_line;
    res_o.verdict        = st_b.verdict;
    res_o.error_field    = (st_b.verdict >= V_EOLN) ? st_b.field_pos : 3'd0;
    res_o.file_has_error = sticky_d;
  end

  // Advance state on each consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StateClear;
      sticky_q <= 1'b0;
    end else if (fire_i) begin
      state_q  <= state_d;
      sticky_q <= sticky_d;
    end
  end

  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && data_i.last_in_line |=> !state_q.decided && state_q.phase == PH_LEAD)
    else $error("line state not cleared after final byte");

  a_undecided_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.decided |-> state_q.verdict == V_VALID)
    else $error("verdict set on undecided line");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && err_now |=> sticky_q)
    else $error("sticky error lost");

endmodule

[hdl/csl_out_stage.sv]
// Result register: holds one verdict beat until the receiver takes it.
// Depends on csl_pkg for the result struct.
`timescale 1ns / 1ps

module csl_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  csl_pkg::csl_out_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output csl_pkg::csl_out_t data_o
);
  import csl_pkg::*;

  logic     valid_q, valid_d;
  csl_out_t data_q;

  // Free when empty or draining this cycle
  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/cron_schedule_line_checker_core.sv]
// Crontab schedule line checker: top level with input register, parser and result register.
// Depends on csl_pkg, csl_parser and csl_out_stage.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one line byte per
//   beat with its last_in_line and new_file flags. Output channel (out_valid_o /
//   out_stall_i / out_data_o) carries one verdict beat per line, produced by the
//   beat marked last_in_line; other bytes produce nothing.
//   Path: a byte accepted into the input register is parsed from there; the edge
//   that moves a final byte into the parser state also loads its verdict into the
//   result register, which raises out_valid_o for the receiver to take.
//   Throughput: one byte per cycle while in_stall_o is low; the per-line parser state
//   is updated by combinational byte logic between the input and state registers.
//   Stall: while a verdict is held in the result register with out_stall_i high
//   and the next final byte sits in the input register, in_stall_o rises;
//   ordinary bytes keep flowing while a verdict waits.
//   Reset: clears the line state, the sticky file error and both valid flags.
//

module cron_schedule_line_checker_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csl_pkg::csl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csl_pkg::csl_out_t out_data_o
);
  import csl_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  csl_in_t  s1_data_q;
  logic     advance;
  logic     in_fire;
  logic     out_ready;
  logic     res_valid;
  csl_out_t res_data;

  // Move the held byte on unless its verdict has nowhere to go
  assign advance    = s1_valid_q && (!s1_data_q.last_in_line || out_ready);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the byte beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  csl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .data_i      (s1_data_q),
    .res_valid_o (res_valid),
    .res_o       (res_data)
  );

  csl_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .data_i  (res_data),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_ready)
    else $error("verdict loaded over an unread result");

endmodule
